FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tick task scheduler table.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int CMP_W      = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);
    localparam logic [15:0]      PEND_MAX  = 16'hFFFF;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_TICK     = 3'd1;
    localparam logic [2:0] CMD_DISPATCH = 3'd2;
    localparam logic [2:0] CMD_DELETE   = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] ERR_NORMAL   = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [1:0] ERR_NO_TASK  = 2'd2;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [15:0] pending;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } table_wr_t;

endpackage

FILE: rtl/tts_table.sv
// ----------------------------------------------------------------------------
// tts_table
// Task table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_table
    import tts_pkg::*;
(
    input  logic             clk,
    input  table_wr_t        wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TASK_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/tick_task_scheduler_table_top.sv
// ----------------------------------------------------------------------------
// tick_task_scheduler_table_top
// Time-triggered task table: add, tick, dispatch, delete and clear commands.
//
// Command channel: cmd_valid / cmd_stall with the command fields. One command
// is taken at a time; cmd_stall is high while a command is being worked.
// Result channel: res_valid / res_stall. Each command yields one closing beat
// with last set; a dispatch first yields one beat per ready task, in table
// order. status and task_count on every beat hold the values after the whole
// command.
// Add, clear, a rejected delete and unused commands go straight to S_FIN,
// which loads the closing beat. Tick and dispatch walk the held entries
// through the table memory, one entry per cycle, then go to S_FIN; dispatch
// first reads back the buffered tag of each ready task in S_EMIT. A delete
// walks from the removed slot to the end of the held entries.
// The next command is taken while the final beat still waits in the output
// register. A stalled receiver holds the output register and, on dispatch,
// pauses the tag read-back. Reset empties the table, clears the error code
// and sets tick_step to 1; the user must write tick_step only while no
// command runs, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_top
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        tick_step_we,
    input  logic [31:0] tick_step_wdata,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  task_tag,
    input  logic [31:0] first_delay,
    input  logic [31:0] period,
    input  logic [3:0]  slot_index,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic        run_valid,
    output logic [7:0]  run_tag,
    output logic [4:0]  task_count,
    output logic        last
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_EMIT, S_FIN} state_t;
    typedef enum logic [1:0] {M_TICK, M_DISPATCH, M_DELETE} mode_t;

    state_t           state_reg;
    mode_t            mode_reg;
    logic [31:0]      tick_step_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       err_reg;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] wptr_reg;
    logic [IDX_W-1:0] data_idx_reg;
    logic [IDX_W-1:0] del_idx_reg;
    logic             rd_pend_reg;
    logic [CNT_W-1:0] nrun_reg;
    logic [CNT_W-1:0] emit_reg;
    logic             fetch_reg;

    logic             res_valid_reg;
    logic [1:0]       status_reg;
    logic             run_valid_reg;
    logic [7:0]       run_tag_reg;
    logic [CNT_W-1:0] task_count_reg;
    logic             last_reg;

    logic [7:0]       tbuf [TASK_SLOTS];
    logic [7:0]       tbuf_q;

    table_wr_t        wr;
    entry_t           rd_data;
    entry_t           upd;
    logic             keep;
    logic             run_hit;
    logic             accept;
    logic             out_free;
    logic             beat_load;
    logic [CNT_W-1:0] emit_next;
    logic [CNT_W-1:0] slot_cnt;
    logic [CNT_W-1:0] walk_start;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign accept     = cmd_valid && !cmd_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign beat_load  = out_free && (((state_reg == S_EMIT) && fetch_reg) ||
                                     (state_reg == S_FIN));
    assign emit_next  = emit_reg + CNT_W'(1);
    assign slot_cnt   = CNT_W'(slot_index);
    assign walk_start = (command == CMD_DELETE) ? slot_cnt : '0;

    tts_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        upd     = rd_data;
        keep    = 1'b1;
        run_hit = 1'b0;
        case (mode_reg)
            M_TICK:
            begin
                if (rd_data.delay != 32'd0)
                begin
                    upd.delay = (rd_data.delay > tick_step_reg) ?
                                rd_data.delay - tick_step_reg : 32'd0;
                end
                else
                begin
                    if (rd_data.pending != PEND_MAX)
                    begin
                        upd.pending = rd_data.pending + 16'd1;
                    end
                    if (rd_data.period != 32'd0)
                    begin
                        upd.delay = rd_data.period;
                    end
                end
            end
            M_DISPATCH:
            begin
                if (rd_data.pending != 16'd0)
                begin
                    run_hit     = 1'b1;
                    upd.pending = rd_data.pending - 16'd1;
                    keep        = (rd_data.period != 32'd0);
                end
            end
            M_DELETE:
            begin
                keep = (data_idx_reg != del_idx_reg);
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        wr.we   = 1'b0;
        wr.addr = wptr_reg[IDX_W-1:0];
        wr.data = upd;
        if (accept && (command == CMD_ADD) && (count_reg < SLOTS_CNT))
        begin
            wr.we           = 1'b1;
            wr.addr         = count_reg[IDX_W-1:0];
            wr.data.tag     = task_tag;
            wr.data.delay   = first_delay;
            wr.data.period  = period;
            wr.data.pending = 16'd0;
        end
        else if ((state_reg == S_WALK) && rd_pend_reg && keep)
        begin
            wr.we = 1'b1;
        end
    end

    // dispatched tags wait here until the final count is known
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WALK) && rd_pend_reg && run_hit)
        begin
            tbuf[nrun_reg[IDX_W-1:0]] <= rd_data.tag;
        end
        tbuf_q <= tbuf[emit_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_TICK;
            tick_step_reg  <= 32'd1;
            count_reg      <= '0;
            err_reg        <= ERR_NORMAL;
            issue_reg      <= '0;
            wptr_reg       <= '0;
            data_idx_reg   <= '0;
            del_idx_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            nrun_reg       <= '0;
            emit_reg       <= '0;
            fetch_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            status_reg     <= ERR_NORMAL;
            run_valid_reg  <= 1'b0;
            run_tag_reg    <= 8'd0;
            task_count_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (tick_step_we)
            begin
                tick_step_reg <= tick_step_wdata;
            end

            if (beat_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        issue_reg   <= walk_start;
                        wptr_reg    <= walk_start;
                        nrun_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        case (command)
                            CMD_ADD:
                            begin
                                if (count_reg < SLOTS_CNT)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    err_reg <= ERR_TOO_MANY;
                                end
                                state_reg <= S_FIN;
                            end
                            CMD_TICK:
                            begin
                                mode_reg  <= M_TICK;
                                state_reg <= S_WALK;
                            end
                            CMD_DISPATCH:
                            begin
                                mode_reg  <= M_DISPATCH;
                                state_reg <= S_WALK;
                            end
                            CMD_DELETE:
                            begin
                                if (CMP_W'(slot_index) >= CMP_W'(count_reg))
                                begin
                                    err_reg   <= ERR_NO_TASK;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    mode_reg    <= M_DELETE;
                                    del_idx_reg <= slot_cnt[IDX_W-1:0];
                                    state_reg   <= S_WALK;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end

                S_WALK:
                begin
                    if (issue_reg < count_reg)
                    begin
                        issue_reg    <= issue_reg + CNT_W'(1);
                        data_idx_reg <= issue_reg[IDX_W-1:0];
                        rd_pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (rd_pend_reg)
                    begin
                        if (keep)
                        begin
                            wptr_reg <= wptr_reg + CNT_W'(1);
                        end
                        if (run_hit)
                        begin
                            nrun_reg <= nrun_reg + CNT_W'(1);
                        end
                    end
                    else if (issue_reg == count_reg)
                    begin
                        count_reg <= wptr_reg;
                        emit_reg  <= '0;
                        fetch_reg <= 1'b0;
                        if ((mode_reg == M_DISPATCH) && (nrun_reg != '0))
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (!fetch_reg)
                    begin
                        fetch_reg <= 1'b1;
                    end
                    else if (out_free)
                    begin
                        status_reg     <= err_reg;
                        run_valid_reg  <= 1'b1;
                        run_tag_reg    <= tbuf_q;
                        task_count_reg <= count_reg;
                        last_reg       <= 1'b0;
                        emit_reg       <= emit_next;
                        fetch_reg      <= 1'b0;
                        if (emit_next == nrun_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        status_reg     <= err_reg;
                        run_valid_reg  <= 1'b0;
                        run_tag_reg    <= 8'd0;
                        task_count_reg <= count_reg;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign run_valid  = run_valid_reg;
    assign run_tag    = run_tag_reg;
    assign task_count = 5'(task_count_reg);
    assign last       = last_reg;

endmodule
